>>> hdl/ddo_pkg.sv
`default_nettype none

package ddo_pkg;

   // Angle constants: 2*pi and pi in 2^-24 rad, pi and pi/2 in Q30.
   localparam logic [26:0]        TWO_PI_Q24 = 27'd105414357;
   localparam logic signed [33:0] PI_Q24 = 34'sd52707179;
   localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam int                 DEF_ITERATIONS = 24;

   // Operation codes.
   localparam logic [2:0] FUNC_UPD_THR = 3'd0;
   localparam logic [2:0] FUNC_UPD = 3'd1;
   localparam logic [2:0] FUNC_UPD_REBASE = 3'd2;
   localparam logic [2:0] FUNC_SET_POSE = 3'd3;
   localparam logic [2:0] FUNC_CLEAR = 3'd4;

   // Register indexes and reset values.
   localparam logic [1:0]  REG_LEFT_PULSE = 2'd0;
   localparam logic [1:0]  REG_RIGHT_PULSE = 2'd1;
   localparam logic [1:0]  REG_WHEEL_BASE = 2'd2;
   localparam logic [1:0]  REG_THRESHOLD = 2'd3;
   localparam logic [31:0] RST_PULSE = 32'd167772;
   localparam logic [31:0] RST_WHEEL_BASE = 32'd13107200;
   localparam logic [31:0] RST_THRESHOLD = 32'd65536;

   // Status of the rotation unit as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } cor_status_type;

   // Arctangent of 2^-i in Q30.
   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0: v = 30'd843314856;
         5'd1: v = 30'd497837829;
         5'd2: v = 30'd263043836;
         5'd3: v = 30'd133525158;
         5'd4: v = 30'd67021686;
         5'd5: v = 30'd33543515;
         5'd6: v = 30'd16775850;
         5'd7: v = 30'd8388437;
         5'd8: v = 30'd4194282;
         5'd9: v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         5'd24: v = 30'd63;
         5'd25: v = 30'd31;
         5'd26: v = 30'd15;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> hdl/ddo_cordic.sv
`default_nettype none

// Cosine and sine in Q30 of an angle in 2^-24 rad, one rotation per cycle.
module ddo_cordic #(
   parameter int ITERATIONS = ddo_pkg::DEF_ITERATIONS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [31:0]     angle,
   output ddo_pkg::cor_status_type     status,
   output logic signed [33:0]          cos_out,
   output logic signed [33:0]          sin_out
);

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_REDUCE = 2'd1;
   localparam logic [1:0] C_FOLD = 2'd2;
   localparam logic [1:0] C_ITER = 2'd3;
   localparam logic [4:0] LAST_STEP = 5'(ITERATIONS - 1);

   logic [1:0]         state_ff, state_in;
   logic [31:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [2:0]         shift_ff, shift_in;
   logic signed [33:0] z_ff, z_in, x_ff, x_in, y_ff, y_in;
   logic               flip_ff, flip_in;
   logic [4:0]         step_ff, step_in;
   logic               done_ff, done_in;

   logic [31:0]        multiple;
   logic signed [33:0] zr, z64, ddx, ddy, xn, yn, zn, atan_s;

   always_comb begin
      state_in = state_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      shift_in = shift_ff;
      z_in = z_ff;
      x_in = x_ff;
      y_in = y_ff;
      flip_in = flip_ff;
      step_in = step_ff;
      done_in = 1'b0;
      multiple = 32'(ddo_pkg::TWO_PI_Q24) << shift_ff;
      zr = '0;
      z64 = '0;
      ddx = y_ff >>> step_ff;
      ddy = x_ff >>> step_ff;
      atan_s = $signed({4'b0000, ddo_pkg::atan_q30(step_ff)});
      xn = '0;
      yn = '0;
      zn = '0;
      unique case (state_ff)
         C_IDLE: begin
            // Take the magnitude; the remainder keeps the sign of the angle.
            if (start) begin
               neg_in = angle[31];
               mag_in = angle[31] ? 32'(-33'(angle)) : 32'(angle);
               shift_in = 3'd4;
               state_in = C_REDUCE;
            end
         end
         C_REDUCE: begin
            // Restoring remainder by 2*pi, one shifted multiple per cycle.
            if (mag_ff >= multiple) begin
               mag_in = mag_ff - multiple;
            end
            shift_in = shift_ff - 3'd1;
            if (shift_ff == 3'd0) begin
               state_in = C_FOLD;
            end
         end
         C_FOLD: begin
            // Bring the angle into plus or minus pi, then into half pi.
            zr = neg_ff ? -34'(mag_ff) : 34'(mag_ff);
            if (zr > ddo_pkg::PI_Q24) begin
               zr = zr - 34'(ddo_pkg::TWO_PI_Q24);
            end else if (zr < -ddo_pkg::PI_Q24) begin
               zr = zr + 34'(ddo_pkg::TWO_PI_Q24);
            end
            z64 = zr <<< 6;
            flip_in = 1'b0;
            if (z64 > ddo_pkg::HALF_PI_Q30) begin
               z64 = z64 - ddo_pkg::PI_Q30;
               flip_in = 1'b1;
            end else if (z64 < -ddo_pkg::HALF_PI_Q30) begin
               z64 = z64 + ddo_pkg::PI_Q30;
               flip_in = 1'b1;
            end
            z_in = z64;
            x_in = ddo_pkg::CORDIC_GAIN_Q30;
            y_in = '0;
            step_in = '0;
            state_in = C_ITER;
         end
         C_ITER: begin
            // One rotation; the last one also applies the half-turn flip.
            if (z_ff >= 0) begin
               xn = x_ff - ddx;
               yn = y_ff + ddy;
               zn = z_ff - atan_s;
            end else begin
               xn = x_ff + ddx;
               yn = y_ff - ddy;
               zn = z_ff + atan_s;
            end
            z_in = zn;
            x_in = xn;
            y_in = yn;
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               x_in = flip_ff ? -xn : xn;
               y_in = flip_ff ? -yn : yn;
               done_in = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      shift_ff <= shift_in;
      z_ff <= z_in;
      x_ff <= x_in;
      y_ff <= y_in;
      flip_ff <= flip_in;
      step_ff <= step_in;
   end

   assign status.busy = (state_ff != C_IDLE);
   assign status.done = done_ff;
   assign cos_out = x_ff;
   assign sin_out = y_ff;

endmodule

`default_nettype wire

>>> hdl/differential_drive_odometry.sv
`default_nettype none

// Channel  Direction  Transfer when          Contents
// req_     in         req_tvalid&req_tready  tuser: func; tdata: counts, new pose
// rsp_     out        rsp_tvalid&rsp_tready  tuser: updated; tdata: pose
// csr_     in         csr_we                 register index and write data
//
// Set pose, clear and unknown operations go from idle through the done state to
// the result register. An update's time is set by the 72-step heading division,
// the 57-step sinc division and two runs of the rotation unit; a zero half turn
// angle skips the sinc division and one run; an update within threshold skips all.
// Reset clears the pose and loads the register defaults; no clearing pass follows.
// One item is in work at a time; the next is taken while a result still waits.
module differential_drive_odometry #(
   parameter int CORDIC_ITERATIONS = ddo_pkg::DEF_ITERATIONS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [2:0]    req_tuser,   // func
   // left_count, right_count, new_x, new_y, new_heading
   input  wire logic [159:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic               rsp_tuser,   // updated
   output logic [95:0]        rsp_tdata,   // pos_x, pos_y, heading
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_index,
   input  wire logic [31:0]   csr_wdata
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MUL_L = 5'd1;
   localparam logic [4:0] S_POST_L = 5'd2;
   localparam logic [4:0] S_MUL_R = 5'd3;
   localparam logic [4:0] S_POST_R = 5'd4;
   localparam logic [4:0] S_CHECK = 5'd5;
   localparam logic [4:0] S_DIV_W = 5'd6;
   localparam logic [4:0] S_ORIENT = 5'd7;
   localparam logic [4:0] S_COR_T = 5'd8;
   localparam logic [4:0] S_DIV_K = 5'd9;
   localparam logic [4:0] S_KSET = 5'd10;
   localparam logic [4:0] S_COR_M = 5'd11;
   localparam logic [4:0] S_MUL_DK = 5'd12;
   localparam logic [4:0] S_POST_DK = 5'd13;
   localparam logic [4:0] S_MUL_X = 5'd14;
   localparam logic [4:0] S_POST_X = 5'd15;
   localparam logic [4:0] S_MUL_Y = 5'd16;
   localparam logic [4:0] S_POST_Y = 5'd17;
   localparam logic [4:0] S_DONE = 5'd18;

   localparam logic signed [56:0] DIST_MAX = 57'sd140737488355327;
   localparam logic signed [56:0] DIST_MIN = -57'sd140737488355328;
   localparam logic [63:0]        LIMIT62 = 64'h4000_0000_0000_0000;
   localparam logic signed [57:0] ONE_Q30 = 58'sd1073741824;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fff_ffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // Product shifted down by 30 with truncation, magnitude limited to 2^62.
   function automatic logic signed [63:0] q30post(input logic [127:0] acc,
                                                  input logic neg);
      logic [63:0] rlo;
      rlo = acc[93:30];
      if ((acc[127:94] != '0) || (rlo > LIMIT62)) begin
         rlo = LIMIT62;
      end
      return neg ? $signed(-rlo) : $signed(rlo);
   endfunction

   // Configuration and pose state.
   logic [31:0]        lpl_ff, lpl_in, rpl_ff, rpl_in, wb_ff, wb_in, thr_ff, thr_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in, cur_ff, cur_in;
   logic signed [31:0] base_ff, base_in, reb_ff, reb_in;
   logic signed [47:0] prevl_ff, prevl_in, prevr_ff, prevr_in;

   // Item in work.
   logic [4:0]         state_ff, state_in;
   logic [2:0]         func_ff, func_in;
   logic signed [31:0] rc_ff, rc_in;
   logic signed [47:0] l_ff, l_in, r_ff, r_in;
   logic signed [48:0] d_ff, d_in;
   logic               negw_ff, negw_in, negk_ff, negk_in;
   logic signed [31:0] orient_ff, orient_in, mean_ff, mean_in, t_ff, t_in;
   logic signed [57:0] k_ff, k_in;
   logic signed [63:0] dk_ff, dk_in;
   logic signed [33:0] c_ff, c_in, s_ff, s_in;
   logic               upd_ff, upd_in;

   // Shared multiplier: four 32 by 32 partial products into an accumulator.
   logic [63:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic [127:0]       acc_ff, acc_in;
   logic [1:0]         mcnt_ff, mcnt_in;
   logic               mneg_ff, mneg_in;
   logic [63:0]        pp;
   logic [127:0]       pp_sh;
   logic               mul_step;

   // Shared restoring divider.
   logic [71:0]        dvd_ff, dvd_in;
   logic [31:0]        dvs_ff, dvs_in, rem_ff, rem_in;
   logic [56:0]        quot_ff, quot_in;
   logic [6:0]         dcnt_ff, dcnt_in;
   logic [32:0]        trial;
   logic               ge;
   logic [27:0]        qwrap;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in, rsp_upd_ff, rsp_upd_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;

   // Rotation unit.
   logic                    cor_start;
   logic signed [31:0]      cor_angle;
   ddo_pkg::cor_status_type cor_stat;
   logic signed [33:0]      cor_cos, cor_sin;

   // Working values.
   logic signed [31:0] lc, nx, ny, nh;
   logic signed [64:0] prod_s;
   logic signed [56:0] prod_sh;
   logic signed [47:0] wheel_dist;
   logic signed [48:0] dl, dr, dw;
   logic signed [49:0] dsum;
   logic signed [27:0] wrap;
   logic signed [33:0] osum;
   logic signed [32:0] angle, msum;
   logic signed [31:0] orient, tval;
   logic signed [63:0] post;
   logic [63:0]        mag_dw, mag_sin, mag_t;

   ddo_cordic #(
      .ITERATIONS(CORDIC_ITERATIONS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .status  (cor_stat),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   assign lc = $signed(req_tdata[31:0]);
   assign nx = $signed(req_tdata[95:64]);
   assign ny = $signed(req_tdata[127:96]);
   assign nh = $signed(req_tdata[159:128]);

   // Partial product select and shift.
   always_comb begin
      pp = (mcnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0])
         * (mcnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0]);
      case (mcnt_ff)
         2'd0: pp_sh = {64'd0, pp};
         2'd3: pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   // Divider step: one quotient bit; the heading quotient is kept modulo 2*pi.
   always_comb begin
      trial = {rem_ff, dvd_ff[71]};
      ge = (trial >= {1'b0, dvs_ff});
      qwrap = {quot_ff[26:0], ge};
      if (qwrap >= 28'(ddo_pkg::TWO_PI_Q24)) begin
         qwrap = qwrap - 28'(ddo_pkg::TWO_PI_Q24);
      end
   end

   // Working values of the current item.
   always_comb begin
      prod_s = mneg_ff ? -$signed({1'b0, acc_ff[63:0]}) : $signed({1'b0, acc_ff[63:0]});
      prod_sh = 57'(prod_s >>> 8);
      if (prod_sh > DIST_MAX) begin
         wheel_dist = DIST_MAX[47:0];
      end else if (prod_sh < DIST_MIN) begin
         wheel_dist = DIST_MIN[47:0];
      end else begin
         wheel_dist = prod_sh[47:0];
      end
      dl = 49'(l_ff) - 49'(prevl_ff);
      dr = 49'(r_ff) - 49'(prevr_ff);
      dw = 49'(r_ff) - 49'(l_ff);
      dsum = 50'(dl) + 50'(dr);
      wrap = negw_ff ? -$signed({1'b0, quot_ff[26:0]}) : $signed({1'b0, quot_ff[26:0]});
      osum = 34'(wrap) + 34'(reb_ff) + 34'(base_ff);
      orient = sat32(66'(osum));
      angle = 33'(orient) - 33'(cur_ff);
      msum = 33'(orient) + 33'(cur_ff);
      tval = 32'(angle >>> 1);
      post = q30post(acc_ff, mneg_ff);
      mag_dw = mag64(64'(dw));
      mag_sin = mag64(64'(cor_sin));
      mag_t = mag64(64'(t_ff));
   end

   // Sequencer.
   always_comb begin
      lpl_in = lpl_ff;
      rpl_in = rpl_ff;
      wb_in = wb_ff;
      thr_in = thr_ff;
      x_in = x_ff;
      y_in = y_ff;
      cur_in = cur_ff;
      base_in = base_ff;
      reb_in = reb_ff;
      prevl_in = prevl_ff;
      prevr_in = prevr_ff;
      state_in = state_ff;
      func_in = func_ff;
      rc_in = rc_ff;
      l_in = l_ff;
      r_in = r_ff;
      d_in = d_ff;
      negw_in = negw_ff;
      negk_in = negk_ff;
      orient_in = orient_ff;
      mean_in = mean_ff;
      t_in = t_ff;
      k_in = k_ff;
      dk_in = dk_ff;
      c_in = c_ff;
      s_in = s_ff;
      upd_in = upd_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      acc_in = acc_ff;
      mcnt_in = mcnt_ff;
      mneg_in = mneg_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      dcnt_in = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_upd_in = rsp_upd_ff;
      rsp_data_in = rsp_data_ff;
      cor_start = 1'b0;
      cor_angle = mean_ff;
      mul_step = (state_ff == S_MUL_L) || (state_ff == S_MUL_R) || (state_ff == S_MUL_DK)
              || (state_ff == S_MUL_X) || (state_ff == S_MUL_Y);

      // Register writes.
      if (csr_we) begin
         unique case (csr_index)
            ddo_pkg::REG_LEFT_PULSE: lpl_in = csr_wdata;
            ddo_pkg::REG_RIGHT_PULSE: rpl_in = csr_wdata;
            ddo_pkg::REG_WHEEL_BASE: wb_in = csr_wdata;
            ddo_pkg::REG_THRESHOLD: thr_in = csr_wdata;
            default: ;
         endcase
      end

      // The result register empties on its transfer.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (mul_step) begin
         acc_in = acc_ff + pp_sh;
         mcnt_in = mcnt_ff + 2'd1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in = req_tuser;
               rc_in = $signed(req_tdata[63:32]);
               state_in = S_DONE;
               upd_in = 1'b0;
               unique case (req_tuser)
                  ddo_pkg::FUNC_UPD_THR, ddo_pkg::FUNC_UPD, ddo_pkg::FUNC_UPD_REBASE: begin
                     ma_in = mag64(64'(lc));
                     mb_in = 64'(lpl_ff);
                     mneg_in = lc[31];
                     acc_in = '0;
                     mcnt_in = '0;
                     state_in = S_MUL_L;
                  end
                  ddo_pkg::FUNC_SET_POSE: begin
                     x_in = nx;
                     y_in = ny;
                     base_in = sat32(66'(nh) - 66'(cur_ff) + 66'(base_ff));
                     cur_in = nh;
                     reb_in = '0;
                     upd_in = 1'b1;
                  end
                  ddo_pkg::FUNC_CLEAR: begin
                     x_in = '0;
                     y_in = '0;
                     base_in = sat32(66'(base_ff) - 66'(cur_ff));
                     cur_in = '0;
                     reb_in = '0;
                     prevl_in = '0;
                     prevr_in = '0;
                     upd_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL_L: if (mcnt_ff == 2'd3) state_in = S_POST_L;
         S_POST_L: begin
            l_in = wheel_dist;
            ma_in = mag64(64'(rc_ff));
            mb_in = 64'(rpl_ff);
            mneg_in = rc_ff[31];
            acc_in = '0;
            mcnt_in = '0;
            state_in = S_MUL_R;
         end
         S_MUL_R: if (mcnt_ff == 2'd3) state_in = S_POST_R;
         S_POST_R: begin
            r_in = wheel_dist;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // For a threshold update, skip when both wheels moved no more than the threshold.
            if ((func_ff == ddo_pkg::FUNC_UPD_THR) && (mag64(64'(dl)) <= 64'(thr_ff))
                && (mag64(64'(dr)) <= 64'(thr_ff))) begin
               upd_in = 1'b0;
               state_in = S_DONE;
            end else begin
               d_in = 49'(dsum >>> 1);
               negw_in = dw[48];
               dvd_in = {mag_dw[47:0], 24'd0};
               dvs_in = (wb_ff == '0) ? 32'd1 : wb_ff;
               rem_in = '0;
               quot_in = '0;
               dcnt_in = 7'd72;
               state_in = S_DIV_W;
            end
         end
         S_DIV_W, S_DIV_K: begin
            rem_in = ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
            dvd_in = {dvd_ff[70:0], 1'b0};
            quot_in = (state_ff == S_DIV_W) ? 57'(qwrap) : {quot_ff[55:0], ge};
            dcnt_in = dcnt_ff - 7'd1;
            if (dcnt_ff == 7'd1) begin
               state_in = (state_ff == S_DIV_W) ? S_ORIENT : S_KSET;
            end
         end
         S_ORIENT: begin
            // New heading, mean heading and half turn angle.
            orient_in = orient;
            mean_in = 32'(msum >>> 1);
            t_in = tval;
            cor_start = 1'b1;
            if (tval == '0) begin
               k_in = ONE_Q30;
               cor_angle = 32'(msum >>> 1);
               state_in = S_COR_M;
            end else begin
               cor_angle = tval;
               state_in = S_COR_T;
            end
         end
         S_COR_T: begin
            // Sinc factor: sin(t) * 2^24 / t.
            if (cor_stat.done) begin
               negk_in = cor_sin[33] ^ t_ff[31];
               dvd_in = {mag_sin[32:0], 39'd0};
               dvs_in = mag_t[31:0];
               rem_in = '0;
               quot_in = '0;
               dcnt_in = 7'd57;
               state_in = S_DIV_K;
            end
         end
         S_KSET: begin
            k_in = negk_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
            cor_start = 1'b1;
            state_in = S_COR_M;
         end
         S_COR_M: begin
            if (cor_stat.done) begin
               c_in = cor_cos;
               s_in = cor_sin;
               ma_in = mag64(64'(d_ff));
               mb_in = mag64(64'(k_ff));
               mneg_in = d_ff[48] ^ k_ff[57];
               acc_in = '0;
               mcnt_in = '0;
               state_in = S_MUL_DK;
            end
         end
         S_MUL_DK: if (mcnt_ff == 2'd3) state_in = S_POST_DK;
         S_POST_DK: begin
            dk_in = post;
            ma_in = mag64(post);
            mb_in = mag64(64'(c_ff));
            mneg_in = post[63] ^ c_ff[33];
            acc_in = '0;
            mcnt_in = '0;
            state_in = S_MUL_X;
         end
         S_MUL_X: if (mcnt_ff == 2'd3) state_in = S_POST_X;
         S_POST_X: begin
            x_in = sat32(66'(x_ff) + 66'(post));
            ma_in = mag64(dk_ff);
            mb_in = mag64(64'(s_ff));
            mneg_in = dk_ff[63] ^ s_ff[33];
            acc_in = '0;
            mcnt_in = '0;
            state_in = S_MUL_Y;
         end
         S_MUL_Y: if (mcnt_ff == 2'd3) state_in = S_POST_Y;
         S_POST_Y: begin
            // Commit the update; a rebase follows it when asked for.
            y_in = sat32(66'(y_ff) + 66'(post));
            cur_in = orient_ff;
            upd_in = 1'b1;
            if (func_ff == ddo_pkg::FUNC_UPD_REBASE) begin
               reb_in = sat32(66'(orient_ff) - 66'(base_ff));
               prevl_in = '0;
               prevr_in = '0;
            end else begin
               prevl_in = l_ff;
               prevr_in = r_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_upd_in = upd_ff;
               rsp_data_in = {cur_ff, y_ff, x_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lpl_ff <= ddo_pkg::RST_PULSE;
         rpl_ff <= ddo_pkg::RST_PULSE;
         wb_ff <= ddo_pkg::RST_WHEEL_BASE;
         thr_ff <= ddo_pkg::RST_THRESHOLD;
         x_ff <= '0;
         y_ff <= '0;
         cur_ff <= '0;
         base_ff <= '0;
         reb_ff <= '0;
         prevl_ff <= '0;
         prevr_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lpl_ff <= lpl_in;
         rpl_ff <= rpl_in;
         wb_ff <= wb_in;
         thr_ff <= thr_in;
         x_ff <= x_in;
         y_ff <= y_in;
         cur_ff <= cur_in;
         base_ff <= base_in;
         reb_ff <= reb_in;
         prevl_ff <= prevl_in;
         prevr_ff <= prevr_in;
      end
      func_ff <= func_in;
      rc_ff <= rc_in;
      l_ff <= l_in;
      r_ff <= r_in;
      d_ff <= d_in;
      negw_ff <= negw_in;
      negk_ff <= negk_in;
      orient_ff <= orient_in;
      mean_ff <= mean_in;
      t_ff <= t_in;
      k_ff <= k_in;
      dk_ff <= dk_in;
      c_ff <= c_in;
      s_ff <= s_in;
      upd_ff <= upd_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      acc_ff <= acc_in;
      mcnt_ff <= mcnt_in;
      mneg_ff <= mneg_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      dcnt_ff <= dcnt_in;
      rsp_upd_ff <= rsp_upd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_upd_ff;
   assign rsp_tdata = rsp_data_ff;

`ifndef ASSERT_OFF
   // An accepted item always leaves the idle state.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != S_IDLE)
      else $error("accepted item did not start");

   // The rotation unit is only started while it is free.
   a_cordic_free: assert property (@(posedge clock) disable iff (reset)
      cor_start |-> !cor_stat.busy)
      else $error("rotation unit started while busy");

   // The divider never runs with an exhausted step count.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_W) || (state_ff == S_DIV_K) |-> dcnt_ff != 7'd0)
      else $error("divider step count exhausted");
`endif

endmodule

`default_nettype wire
